// ===== hw/rtl/udcd_pkg.sv =====
// Shared types and constants for the up/down decimal counter display core.
// No dependencies; imported by every module of the block.
package udcd_pkg;

  // Counter state: four decimal digits, 0 to 9999.
  localparam int CNT_DIGITS = 4;
  localparam int IDX_W      = 3;  // beat index inside a phase (setup or up to 8 digits)

  typedef logic [3:0]                 bcd_t;
  typedef logic [CNT_DIGITS-1:0][3:0] bcd_word_t;
  typedef logic [13:0]                count_t;

  // Display driver register addresses.
  localparam logic [3:0] REG_DECODE    = 4'd9;
  localparam logic [3:0] REG_INTENSITY = 4'd10;
  localparam logic [3:0] REG_SCAN      = 4'd11;
  localparam logic [3:0] REG_SHUTDOWN  = 4'd12;
  localparam logic [3:0] REG_TEST      = 4'd15;

  // Setup beat order.
  localparam logic [IDX_W-1:0] SETUP_DECODE    = 3'd0;
  localparam logic [IDX_W-1:0] SETUP_SCAN      = 3'd1;
  localparam logic [IDX_W-1:0] SETUP_INTENSITY = 3'd2;
  localparam logic [IDX_W-1:0] SETUP_TEST      = 3'd3;
  localparam logic [IDX_W-1:0] SETUP_SHUTDOWN  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TICK_PERIOD = 2'd0;
  localparam logic [1:0] CFG_INTENSITY   = 2'd1;
  localparam logic [1:0] CFG_SCAN_LIMIT  = 2'd2;
  localparam logic [1:0] CFG_DECODE_MODE = 2'd3;

  localparam logic [7:0] TICK_PERIOD_RST = 8'd25;
  localparam logic [3:0] INTENSITY_RST   = 4'd4;
  localparam logic [2:0] SCAN_LIMIT_RST  = 3'd3;
  localparam logic [7:0] DECODE_MODE_RST = 8'h0F;

  // Control shared by every digit cell for one accepted item.
  typedef struct packed {
    logic upd;      // item accepted, commit the new digit
    logic play;     // automatic mode: clear happens before the step
    logic up;       // direction
    logic do_step;  // one increment/decrement rides the carry chain
    logic do_load;  // clear: load 0 (up) or 9 (down)
  } cell_ctl_t;

  // Values the write sequencer sends during a start command.
  typedef struct packed {
    logic [7:0] decode_mode;
    logic [2:0] scan_limit;
    logic [3:0] intensity_level;
  } setup_cfg_t;

  // One item's worth of display writes.
  typedef struct packed {
    logic      start;   // setup writes, then set A
    logic      has_a;
    logic      has_b;
    bcd_word_t set_a;
    bcd_word_t set_b;
    count_t    count;   // counter value after the item
  } wr_item_t;

  typedef enum logic [1:0] {
    PH_SETUP,
    PH_SET_A,
    PH_SET_B
  } phase_t;

endpackage

// ===== hw/rtl/updown_decimal_counter_display_core.sv =====
// Up/down decimal counter with display-driver write stream (top level).
// Depends on udcd_pkg, udcd_digit_cell and udcd_write_seq.
// Latency: the input item passes the pending slot and then the active slot before its first write beat.
// Throughput: one write beat per cycle while out_ready is high; a start gives five setup writes
//   and then DIGITS digit writes, a tick DIGITS writes per counter change, a tick with no change none.
// Reset: counter 0, prescaler 0, buttons released, registers at their defaults.
module updown_decimal_counter_display_core #(
  parameter int DIGITS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  // sample / start beats
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic                in_play_on,
  input  logic                in_count_up,
  input  logic                in_step_level,
  input  logic                in_step_recheck,
  input  logic                in_clear_level,
  input  logic                in_clear_recheck,
  // display write beats
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_reg_address,
  output logic [7:0]          out_reg_data,
  output udcd_pkg::count_t    out_count_value,
  output logic                out_last,
  // register writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import udcd_pkg::*;

  // Configuration registers.
  logic [7:0] tick_period_r;
  logic [3:0] intensity_r;
  logic [2:0] scan_limit_r;
  logic [7:0] decode_mode_r;

  // Sample state.
  logic [7:0] tick_count_r, tick_count_nxt;
  logic       prev_step_r, prev_step_nxt;
  logic       prev_clear_r, prev_clear_nxt;

  logic       in_fire, tick;
  logic       step_fire, clear_fire, pre_fire;
  logic [8:0] tick_inc;
  cell_ctl_t  ctl;

  // Digit chain wiring: carry runs upward, binary value runs downward.
  logic      [CNT_DIGITS:0] carry;
  count_t    part [CNT_DIGITS+1];
  bcd_word_t cur_digits, step_digits, load_digits;

  wr_item_t   item;
  logic       item_vld, item_rdy;
  setup_cfg_t setup;

  assign in_fire   = in_valid && in_ready;
  assign tick      = in_fire && !in_command;
  assign cfg_ready = 1'b1;

  // Debounced falling edges; manual step only counts with play off.
  assign step_fire  = prev_step_r && !in_step_level && !in_step_recheck && !in_play_on;
  assign clear_fire = prev_clear_r && !in_clear_level && !in_clear_recheck;

  // Prescaler: advance while playing, fire and drop back to zero at the period.
  assign tick_inc = {1'b0, tick_count_r} + 9'd1;
  assign pre_fire = in_play_on && (tick_inc >= {1'b0, tick_period_r});

  always_comb begin
    tick_count_nxt = tick_count_r;
    prev_step_nxt  = prev_step_r;
    prev_clear_nxt = prev_clear_r;
    if (tick) begin
      prev_step_nxt  = in_step_level;
      prev_clear_nxt = in_clear_level;
      if (in_play_on) begin
        tick_count_nxt = pre_fire ? 8'd0 : tick_inc[7:0];
      end
    end
  end

  // A tick carries at most one step (manual with play off, prescaler with play on)
  // and at most one clear, so one pass of the carry chain covers the whole beat.
  always_comb begin
    ctl.upd     = in_fire;
    ctl.play    = in_play_on;
    ctl.up      = in_count_up;
    ctl.do_step = tick && (step_fire || pre_fire);
    ctl.do_load = tick && clear_fire;
  end

  assign carry[0]         = ctl.do_step;
  assign part[CNT_DIGITS] = '0;

  for (genvar g = 0; g < CNT_DIGITS; g++) begin : g_cell
    udcd_digit_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .cin    (carry[g]),
      .cout   (carry[g+1]),
      .part_i (part[g+1]),
      .part_o (part[g]),
      .cur_o  (cur_digits[g]),
      .step_o (step_digits[g])
    );
  end

  always_comb begin
    for (int j = 0; j < CNT_DIGITS; j++) begin
      load_digits[j] = in_count_up ? 4'd0 : 4'd9;
    end
  end

  // Order the writes: with play off the step comes before the clear,
  // with play on the clear comes before the prescaler step.
  always_comb begin
    item.start = in_command;
    item.count = part[0];
    if (in_command) begin
      item.has_a = 1'b1;
      item.has_b = 1'b0;
      item.set_a = cur_digits;
      item.set_b = cur_digits;
    end else if (!in_play_on) begin
      item.has_a = step_fire;
      item.has_b = clear_fire;
      item.set_a = step_digits;
      item.set_b = load_digits;
    end else begin
      item.has_a = clear_fire;
      item.has_b = pre_fire;
      item.set_a = load_digits;
      item.set_b = step_digits;
    end
  end

  // Beats that change nothing leave no writes behind.
  assign item_vld = in_fire && (item.start || item.has_a || item.has_b);
  assign in_ready = item_rdy;

  always_comb begin
    setup.decode_mode     = decode_mode_r;
    setup.scan_limit      = scan_limit_r;
    setup.intensity_level = intensity_r;
  end

  udcd_write_seq #(
    .DIGITS (DIGITS)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_vld        (item_vld),
    .item_rdy        (item_rdy),
    .item            (item),
    .setup           (setup),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_reg_address (out_reg_address),
    .out_reg_data    (out_reg_data),
    .out_count_value (out_count_value),
    .out_last        (out_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= 8'd0;
      prev_step_r  <= 1'b1;
      prev_clear_r <= 1'b1;
    end else begin
      tick_count_r <= tick_count_nxt;
      prev_step_r  <= prev_step_nxt;
      prev_clear_r <= prev_clear_nxt;
    end
  end

  // Register writes; always accepted, the host must write only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r <= TICK_PERIOD_RST;
      intensity_r   <= INTENSITY_RST;
      scan_limit_r  <= SCAN_LIMIT_RST;
      decode_mode_r <= DECODE_MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TICK_PERIOD: tick_period_r <= cfg_data;
        CFG_INTENSITY:   intensity_r   <= cfg_data[3:0];
        CFG_SCAN_LIMIT:  scan_limit_r  <= cfg_data[2:0];
        CFG_DECODE_MODE: decode_mode_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/udcd_digit_cell.sv =====
// One decimal digit of the counter: digit register, carry/borrow, clear load.
// Depends on udcd_pkg; chained by the top level, least significant cell first.
module udcd_digit_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  udcd_pkg::cell_ctl_t ctl,
  input  logic              cin,     // step request from the lower neighbor
  output logic              cout,    // step request to the upper neighbor
  input  udcd_pkg::count_t  part_i,  // binary value of the digits above
  output udcd_pkg::count_t  part_o,
  output udcd_pkg::bcd_t    cur_o,   // digit before this item
  output udcd_pkg::bcd_t    step_o   // digit right after the step
);
  import udcd_pkg::*;

  bcd_t digit_r, digit_nxt;
  bcd_t ld_val, base, stepped, fin;

  always_comb begin
    ld_val = ctl.up ? 4'd0 : 4'd9;
    // In play mode the clear precedes the step, so the step starts from the load.
    base   = (ctl.play && ctl.do_load) ? ld_val : digit_r;
    cout   = 1'b0;
    stepped = base;
    if (cin) begin
      if (ctl.up) begin
        if (base == 4'd9) begin
          stepped = 4'd0;
          cout    = 1'b1;
        end else begin
          stepped = base + 4'd1;
        end
      end else begin
        if (base == 4'd0) begin
          stepped = 4'd9;
          cout    = 1'b1;
        end else begin
          stepped = base - 4'd1;
        end
      end
    end
    // Manual mode: the clear comes last and wins.
    fin       = (!ctl.play && ctl.do_load) ? ld_val : stepped;
    digit_nxt = ctl.upd ? fin : digit_r;
  end

  assign part_o = 14'(part_i << 3) + 14'(part_i << 1) + {10'd0, fin};
  assign cur_o  = digit_r;
  assign step_o = stepped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= 4'd0;
    end else begin
      digit_r <= digit_nxt;
    end
  end

endmodule

// ===== hw/rtl/udcd_write_seq.sv =====
// Display write sequencer: a pending slot and an active slot, one write per beat.
// Depends on udcd_pkg.
module udcd_write_seq #(
  parameter int DIGITS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_vld,
  output logic                  item_rdy,
  input  udcd_pkg::wr_item_t    item,
  input  udcd_pkg::setup_cfg_t  setup,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            out_reg_address,
  output logic [7:0]            out_reg_data,
  output udcd_pkg::count_t      out_count_value,
  output logic                  out_last
);
  import udcd_pkg::*;

  localparam logic [IDX_W-1:0] LastDig = IDX_W'(DIGITS - 1);

  logic               p_vld_r, p_vld_nxt;
  wr_item_t           p_r;
  logic               s_vld_r, s_vld_nxt;
  wr_item_t           s_r;
  phase_t             ph_r, ph_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  logic      out_fire, beat_last, s_load, push;
  bcd_word_t src;
  bcd_t      dig;

  always_comb begin
    unique case (ph_r)
      PH_SET_A: beat_last = (idx_r == LastDig) && !s_r.has_b;
      PH_SET_B: beat_last = (idx_r == LastDig);
      default:  beat_last = 1'b0;
    endcase
  end

  assign out_fire = s_vld_r && out_ready;
  assign s_load   = p_vld_r && (!s_vld_r || (out_fire && beat_last));
  assign item_rdy = !p_vld_r || s_load;
  assign push     = item_vld && item_rdy;

  // Slot and beat pointer update.
  always_comb begin
    p_vld_nxt = push ? 1'b1 : (s_load ? 1'b0 : p_vld_r);
    s_vld_nxt = s_vld_r;
    ph_nxt    = ph_r;
    idx_nxt   = idx_r;
    if (s_load) begin
      s_vld_nxt = 1'b1;
      ph_nxt    = p_r.start ? PH_SETUP : (p_r.has_a ? PH_SET_A : PH_SET_B);
      idx_nxt   = '0;
    end else if (out_fire) begin
      if (beat_last) begin
        s_vld_nxt = 1'b0;
      end else begin
        unique case (ph_r)
          PH_SETUP: begin
            if (idx_r == SETUP_SHUTDOWN) begin
              ph_nxt  = PH_SET_A;
              idx_nxt = '0;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          PH_SET_A: begin
            if (idx_r == LastDig) begin
              ph_nxt  = PH_SET_B;
              idx_nxt = '0;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          default: idx_nxt = idx_r + 1'b1;
        endcase
      end
    end
  end

  // Digit k (1 = most significant) sits at decimal position DIGITS - k.
  always_comb begin
    src = (ph_r == PH_SET_B) ? s_r.set_b : s_r.set_a;
    dig = 4'd0;
    for (int j = 0; j < CNT_DIGITS; j++) begin
      if ((DIGITS - 1 - j) >= 0) begin
        if (idx_r == IDX_W'(DIGITS - 1 - j)) begin
          dig = src[j];
        end
      end
    end
  end

  always_comb begin
    out_reg_address = 4'(idx_r) + 4'd1;
    out_reg_data    = {4'd0, dig};
    if (ph_r == PH_SETUP) begin
      unique case (idx_r)
        SETUP_DECODE: begin
          out_reg_address = REG_DECODE;
          out_reg_data    = setup.decode_mode;
        end
        SETUP_SCAN: begin
          out_reg_address = REG_SCAN;
          out_reg_data    = {5'd0, setup.scan_limit};
        end
        SETUP_INTENSITY: begin
          out_reg_address = REG_INTENSITY;
          out_reg_data    = {4'd0, setup.intensity_level};
        end
        SETUP_TEST: begin
          out_reg_address = REG_TEST;
          out_reg_data    = 8'd0;
        end
        SETUP_SHUTDOWN: begin
          out_reg_address = REG_SHUTDOWN;
          out_reg_data    = 8'd1;
        end
        default: begin
          out_reg_address = REG_TEST;
          out_reg_data    = 8'd0;
        end
      endcase
    end
  end

  assign out_valid       = s_vld_r;
  assign out_count_value = s_r.count;
  assign out_last        = beat_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
      ph_r    <= PH_SETUP;
      idx_r   <= '0;
    end else begin
      p_vld_r <= p_vld_nxt;
      s_vld_r <= s_vld_nxt;
      ph_r    <= ph_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      p_r <= item;
    end
    if (s_load) begin
      s_r <= p_r;
    end
  end

endmodule
